>>> src/dswq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswq_pkg: shared types for the deadline-sorted work queue
// Item and result structs, operation codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dswq_pkg;

    localparam int TAG_W   = 16;
    localparam int TIME_W  = 64;
    localparam int CNT_W   = 5;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [1:0] FUNC_POLL    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [TAG_W-1:0]  item_tag;
        logic [TIME_W-1:0] item_deadline;
        logic [TIME_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              popped;
        logic [TAG_W-1:0]  out_tag;
        logic [TIME_W-1:0] out_deadline;
        logic [CNT_W-1:0]  entry_count;
        logic [CNT_W-1:0]  peak_count;
        logic              head_valid;
        logic [TIME_W-1:0] head_deadline;
    } t_out_item;

    // What every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [TAG_W-1:0]  new_tag;
        logic [TIME_W-1:0] new_deadline;
    } t_cell_ctrl;

endpackage

>>> src/deadline_sorted_work_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_sorted_work_queue: sorted deadline priority queue
// Keeps up to DEPTH items ordered by deadline in a chain of cells; enqueue
// inserts in place, poll pops a ready head, clear empties the store.
// ----------------------------------------------------------------------------
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+-------------------------------
//  command   | i_start, o_busy, i_item       | taken when i_start && !o_busy
//  result    | o_done, o_result              | one-cycle strobe, no back-pressure
//
// Cycles: the whole chain of cells compares against the new deadline and
// shifts in parallel, so o_done rises in the cycle after the item is taken
// and o_busy never rises. A new item may be issued in every cycle.
// Reset: synchronous, active low; clears the held and peak counts. Cell
// contents are not cleared: slots at or beyond the count are never read.
// Stalls: none; the receiver must take each result in its strobe cycle.
// ----------------------------------------------------------------------------
module deadline_sorted_work_queue #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  dswq_pkg::t_in_item  i_item,
    output logic                o_done,
    output dswq_pkg::t_out_item o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    // Count registers
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_peak;
    logic [CW-1:0] n_peak;

    // Result side: per-operation outcome, registered at acceptance
    logic                          r_done;
    logic                          r_accepted;
    logic                          r_popped;
    logic [dswq_pkg::TAG_W-1:0]    r_out_tag;
    logic [dswq_pkg::TIME_W-1:0]   r_out_deadline;
    logic                          n_accepted;
    logic                          n_popped;
    logic [dswq_pkg::TAG_W-1:0]    n_out_tag;
    logic [dswq_pkg::TIME_W-1:0]   n_out_deadline;

    logic                 take;
    logic                 full;
    logic                 head_ready;
    dswq_pkg::t_cell_ctrl cell_ctrl;

    // Chain wiring
    logic                        cell_ge       [DEPTH];
    logic [dswq_pkg::TAG_W-1:0]  cell_tag      [DEPTH];
    logic [dswq_pkg::TIME_W-1:0] cell_deadline [DEPTH];

    logic [CW+dswq_pkg::CNT_W-1:0] count_ext;
    logic [CW+dswq_pkg::CNT_W-1:0] peak_ext;

    assign o_busy = 1'b0;
    assign take   = i_start && !o_busy;
    assign full   = (r_count == CW'(DEPTH));
    // Head is ready when its deadline is not later than the current time
    assign head_ready = (r_count != '0) && (cell_deadline[0] <= i_item.now_time);

    // Decode the operation into cell commands and the next counts
    always_comb begin
        cell_ctrl.op           = dswq_pkg::CELL_HOLD;
        cell_ctrl.new_tag      = i_item.item_tag;
        cell_ctrl.new_deadline = i_item.item_deadline;
        n_count        = r_count;
        n_accepted     = 1'b1;
        n_popped       = 1'b0;
        n_out_tag      = '0;
        n_out_deadline = '0;
        if (take) begin
            case (i_item.func)
                dswq_pkg::FUNC_ENQUEUE: begin
                    if (full) begin
                        n_accepted = 1'b0;
                    end else begin
                        cell_ctrl.op = dswq_pkg::CELL_INSERT;
                        n_count      = r_count + CW'(1);
                    end
                end
                dswq_pkg::FUNC_POLL: begin
                    if (head_ready) begin
                        cell_ctrl.op   = dswq_pkg::CELL_POP;
                        n_count        = r_count - CW'(1);
                        n_popped       = 1'b1;
                        n_out_tag      = cell_tag[0];
                        n_out_deadline = cell_deadline[0];
                    end
                end
                dswq_pkg::FUNC_CLEAR: begin
                    // drop every item; cell contents go stale behind a zero count
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign n_peak = (n_count > r_peak) ? n_count : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_peak  <= n_peak;
            r_done  <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_accepted     <= n_accepted;
            r_popped       <= n_popped;
            r_out_tag      <= n_out_tag;
            r_out_deadline <= n_out_deadline;
        end
    end

    // Row of cells; slot zero is the head, later slots hold deadlines no earlier
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                        prev_ge;
        logic [dswq_pkg::TAG_W-1:0]  prev_tag;
        logic [dswq_pkg::TIME_W-1:0] prev_deadline;
        logic [dswq_pkg::TAG_W-1:0]  next_tag;
        logic [dswq_pkg::TIME_W-1:0] next_deadline;

        if (i == 0) begin : g_first
            assign prev_ge       = 1'b1;
            assign prev_tag      = '0;
            assign prev_deadline = '0;
        end else begin : g_mid
            assign prev_ge       = cell_ge[i-1];
            assign prev_tag      = cell_tag[i-1];
            assign prev_deadline = cell_deadline[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_tag      = '0;
            assign next_deadline = '0;
        end else begin : g_inner
            assign next_tag      = cell_tag[i+1];
            assign next_deadline = cell_deadline[i+1];
        end

        dswq_cell u_cell (
            .i_clk           (i_clk),
            .i_ctrl          (cell_ctrl),
            .i_occupied      (CW'(i) < r_count),
            .i_prev_ge       (prev_ge),
            .i_prev_tag      (prev_tag),
            .i_prev_deadline (prev_deadline),
            .i_next_tag      (next_tag),
            .i_next_deadline (next_deadline),
            .o_ge            (cell_ge[i]),
            .o_tag           (cell_tag[i]),
            .o_deadline      (cell_deadline[i])
        );
    end

    // Status fields read the post-operation state straight from the registers
    assign count_ext = {{dswq_pkg::CNT_W{1'b0}}, r_count};
    assign peak_ext  = {{dswq_pkg::CNT_W{1'b0}}, r_peak};

    assign o_done                 = r_done;
    assign o_result.accepted      = r_accepted;
    assign o_result.popped        = r_popped;
    assign o_result.out_tag       = r_out_tag;
    assign o_result.out_deadline  = r_out_deadline;
    assign o_result.entry_count   = count_ext[dswq_pkg::CNT_W-1:0];
    assign o_result.peak_count    = peak_ext[dswq_pkg::CNT_W-1:0];
    assign o_result.head_valid    = (r_count != '0);
    assign o_result.head_deadline = (r_count != '0) ? cell_deadline[0] : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("held count exceeds depth");

    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("peak count below held count");

    a_pop_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.popped |-> o_result.accepted && o_result.head_valid == (r_count != '0))
        else $error("popped result flagged as rejected");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.func == dswq_pkg::FUNC_CLEAR |=> o_done && r_count == '0)
        else $error("clear left items in the queue");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.func == dswq_pkg::FUNC_ENQUEUE && full |=> !o_result.accepted && $stable(r_count))
        else $error("enqueue into a full queue was stored");

endmodule

>>> src/dswq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswq_cell: one slot of the sorted chain
// Holds one tag and deadline; keeps, takes the new item, or shifts from a
// neighbour so that the chain stays sorted by deadline.
// ----------------------------------------------------------------------------
module dswq_cell (
    input  logic                       i_clk,
    input  dswq_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_occupied,
    input  logic                       i_prev_ge,
    input  logic [dswq_pkg::TAG_W-1:0]  i_prev_tag,
    input  logic [dswq_pkg::TIME_W-1:0] i_prev_deadline,
    input  logic [dswq_pkg::TAG_W-1:0]  i_next_tag,
    input  logic [dswq_pkg::TIME_W-1:0] i_next_deadline,
    output logic                       o_ge,
    output logic [dswq_pkg::TAG_W-1:0]  o_tag,
    output logic [dswq_pkg::TIME_W-1:0] o_deadline
);

    logic [dswq_pkg::TAG_W-1:0]  r_tag;
    logic [dswq_pkg::TIME_W-1:0] r_deadline;
    logic [dswq_pkg::TAG_W-1:0]  n_tag;
    logic [dswq_pkg::TIME_W-1:0] n_deadline;

    // Stays ahead of the new item: equal deadlines keep arrival order
    assign o_ge = i_occupied && (r_deadline <= i_ctrl.new_deadline);

    always_comb begin
        n_tag      = r_tag;
        n_deadline = r_deadline;
        case (i_ctrl.op)
            dswq_pkg::CELL_INSERT: begin
                if (!o_ge) begin
                    if (i_prev_ge) begin
                        n_tag      = i_ctrl.new_tag;
                        n_deadline = i_ctrl.new_deadline;
                    end else begin
                        n_tag      = i_prev_tag;
                        n_deadline = i_prev_deadline;
                    end
                end
            end
            dswq_pkg::CELL_POP: begin
                n_tag      = i_next_tag;
                n_deadline = i_next_deadline;
            end
            default: begin
                n_tag      = r_tag;
                n_deadline = r_deadline;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_deadline <= n_deadline;
    end

    assign o_tag      = r_tag;
    assign o_deadline = r_deadline;

endmodule
